// ===== rtl/actm_pkg.sv =====
package actm_pkg;

  localparam int NUM_ENTRIES      = 16384;
  localparam int RESERVED_ENTRIES = 3;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 14;
  localparam int LINK_W = 15;
  localparam int CNT_W  = 15;
  localparam int ST_W   = 2;

  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int SEARCH_SPAN = (NUM_ENTRIES < 16384) ? NUM_ENTRIES : 16384;
  localparam int SCAN_W      = $clog2(SEARCH_SPAN + 1);
  localparam int USED_W      = $clog2(NUM_ENTRIES + 1);
  localparam int RESV_USED   = (RESERVED_ENTRIES < NUM_ENTRIES) ? RESERVED_ENTRIES : NUM_ENTRIES;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [LINK_W-1:0] END_MARK = {LINK_W{1'b1}};

  localparam logic [OP_W-1:0] OP_FORMAT = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;
  localparam logic [ST_W-1:0] ST_LOOP = 2'd3;

  typedef enum logic [2:0] {
    CMD_FORMAT,
    CMD_ALLOC,
    CMD_APPEND,
    CMD_FREE,
    CMD_NEXT,
    CMD_COUNT,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] index;
    logic             idx_ok;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] freed_or_used;
    logic             end_of_chain;
    logic [IDX_W-1:0] result_index;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_CLEAR,
    BK_RDIDX,
    BK_SCAN,
    BK_SCAN_CHK,
    BK_LINK,
    BK_FREE_RD,
    BK_FREE_CHK,
    BK_DONE
  } bk_state_t;

endpackage

// ===== rtl/allocation_table_chain_manager.sv =====
// Allocation table chain manager: keeps a linked table of 16384 15-bit entries in one
// single-port-write RAM with registered read, and runs one operation per item with one
// result item each. Format sweeps the whole table, one entry a cycle, and every other
// operation answers status 2 until the first format. Allocate and append scan for the
// lowest free entry from a hint kept below which every entry is in use, reading each
// entry looked at and then checking it. Free chain reads and clears each entry walked.
// A short command queue lets new items be taken while an operation runs or a result
// waits.
module allocation_table_chain_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[2:0], entry_index[16:3], zero[23:17]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result_index[13:0], end_of_chain[14],
                                  // freed_or_used[29:15], status[31:30]
);
  import actm_pkg::*;

  logic              push_valid;
  logic              push_ready;
  cmd_t              push_cmd;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_cmd;
  ram_req_t          ram_req;
  logic [LINK_W-1:0] ram_rdata;
  result_t           out_data;

  actm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_opcode      (in_tdata[OP_W-1:0]),
    .in_entry_index (in_tdata[OP_W+IDX_W-1:OP_W]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  actm_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd)
  );

  actm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  actm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {out_data.status, out_data.freed_or_used,
                      out_data.end_of_chain, out_data.result_index};

endmodule

// ===== rtl/actm_ram.sv =====
module actm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/actm_front.sv =====
module actm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [actm_pkg::OP_W-1:0]  in_opcode,
  input  logic [actm_pkg::IDX_W-1:0] in_entry_index,
  output logic                       push_valid,
  input  logic                       push_ready,
  output actm_pkg::cmd_t             push_cmd
);
  import actm_pkg::*;

  logic vld_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  always_comb begin
    cmd_nxt.index  = in_entry_index;
    cmd_nxt.idx_ok = (32'(in_entry_index) < NUM_ENTRIES);
    unique case (in_opcode)
      OP_FORMAT: cmd_nxt.kind = CMD_FORMAT;
      OP_ALLOC:  cmd_nxt.kind = CMD_ALLOC;
      OP_APPEND: cmd_nxt.kind = CMD_APPEND;
      OP_FREE:   cmd_nxt.kind = CMD_FREE;
      OP_NEXT:   cmd_nxt.kind = CMD_NEXT;
      OP_COUNT:  cmd_nxt.kind = CMD_COUNT;
      default:   cmd_nxt.kind = CMD_BAD;
    endcase
  end

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_cmd   = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/actm_cmd_queue.sv =====
module actm_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  actm_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           q_valid,
  output actm_pkg::cmd_t q_cmd
);
  import actm_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (32'(count_r) < QUEUE_DEPTH);
  assign q_valid    = (count_r != '0);
  assign q_cmd      = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && q_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/actm_back.sv =====
module actm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  actm_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output actm_pkg::ram_req_t          ram_req,
  input  logic [actm_pkg::LINK_W-1:0] ram_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output actm_pkg::result_t           out_data
);
  import actm_pkg::*;

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [LINK_W-1:0] link_r, link_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [SCAN_W-1:0] hint_r, hint_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [USED_W-1:0] cnt_r, cnt_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              formatted_r, formatted_nxt;
  result_t           res_r, res_nxt;
  logic              out_vld_r, out_vld_nxt;
  result_t           out_data_r, out_data_nxt;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ENTRIES - 1);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    link_nxt      = link_r;
    scan_nxt      = scan_r;
    hint_nxt      = hint_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    formatted_nxt = formatted_r;
    res_nxt       = res_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = cur_r;
    ram_req.wdata = '0;
    ram_req.raddr = cur_r;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          res_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_DISPATCH;
        end
      end
      BK_DISPATCH: begin
        ram_req.raddr = ADDR_W'(cmd_r.index);
        cur_nxt       = ADDR_W'(cmd_r.index);
        scan_nxt      = hint_r;
        if (cmd_r.kind == CMD_FORMAT) begin
          cur_nxt   = '0;
          state_nxt = BK_CLEAR;
        end else if (!formatted_r || cmd_r.kind == CMD_BAD) begin
          res_nxt.status = ST_BAD;
          state_nxt      = BK_DONE;
        end else begin
          unique case (cmd_r.kind)
            CMD_COUNT: begin
              res_nxt.freed_or_used = CNT_W'(used_r);
              state_nxt             = BK_DONE;
            end
            CMD_ALLOC: begin
              state_nxt = BK_SCAN;
            end
            default: begin
              if (!cmd_r.idx_ok) begin
                res_nxt.status = ST_BAD;
                state_nxt      = BK_DONE;
              end else begin
                state_nxt = BK_RDIDX;
              end
            end
          endcase
        end
      end
      BK_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_r;
        ram_req.wdata = (32'(cur_r) < RESERVED_ENTRIES) ? END_MARK : '0;
        cur_nxt       = cur_r + 1'b1;
        if (cur_r == LAST_ADDR) begin
          formatted_nxt = 1'b1;
          used_nxt      = USED_W'(RESV_USED);
          hint_nxt      = SCAN_W'(1);
          state_nxt     = BK_DONE;
        end
      end
      BK_RDIDX: begin
        link_nxt = ram_rdata;
        if (ram_rdata == '0) begin
          res_nxt.status = ST_BAD;
          state_nxt      = BK_DONE;
        end else begin
          unique case (cmd_r.kind)
            CMD_NEXT: begin
              if (ram_rdata == END_MARK) begin
                res_nxt.end_of_chain = 1'b1;
              end else begin
                res_nxt.result_index = IDX_W'(ram_rdata);
              end
              state_nxt = BK_DONE;
            end
            CMD_APPEND: begin
              state_nxt = BK_SCAN;
            end
            default: begin
              state_nxt = BK_FREE_RD;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (32'(scan_r) >= SEARCH_SPAN) begin
          res_nxt.status = ST_FULL;
          hint_nxt       = SCAN_W'(SEARCH_SPAN);
          state_nxt      = BK_DONE;
        end else begin
          ram_req.raddr = ADDR_W'(scan_r);
          state_nxt     = BK_SCAN_CHK;
        end
      end
      BK_SCAN_CHK: begin
        if (ram_rdata == '0) begin
          ram_req.we           = 1'b1;
          ram_req.waddr        = ADDR_W'(scan_r);
          res_nxt.result_index = IDX_W'(scan_r);
          hint_nxt             = scan_r + 1'b1;
          used_nxt             = used_r + 1'b1;
          if (cmd_r.kind == CMD_APPEND) begin
            ram_req.wdata = link_r;
            state_nxt     = BK_LINK;
          end else begin
            ram_req.wdata = END_MARK;
            state_nxt     = BK_DONE;
          end
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = BK_SCAN;
        end
      end
      BK_LINK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(cmd_r.index);
        ram_req.wdata = LINK_W'(scan_r);
        state_nxt     = BK_DONE;
      end
      BK_FREE_RD: begin
        ram_req.raddr = cur_r;
        state_nxt     = BK_FREE_CHK;
      end
      BK_FREE_CHK: begin
        if (ram_rdata == '0) begin
          res_nxt.status        = ST_LOOP;
          res_nxt.freed_or_used = CNT_W'(cnt_r);
          state_nxt             = BK_DONE;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cur_r;
          ram_req.wdata = '0;
          cnt_nxt       = cnt_r + 1'b1;
          if (used_r != '0) begin
            used_nxt = used_r - 1'b1;
          end
          if (cur_r != '0 && 32'(cur_r) < 32'(hint_r)) begin
            hint_nxt = SCAN_W'(cur_r);
          end
          if (ram_rdata == END_MARK) begin
            res_nxt.freed_or_used = CNT_W'(cnt_r + 1'b1);
            state_nxt             = BK_DONE;
          end else if (32'(ram_rdata) >= NUM_ENTRIES) begin
            res_nxt.status        = ST_BAD;
            res_nxt.freed_or_used = CNT_W'(cnt_r + 1'b1);
            state_nxt             = BK_DONE;
          end else begin
            cur_nxt   = ADDR_W'(ram_rdata);
            state_nxt = BK_FREE_RD;
          end
        end
      end
      BK_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          state_nxt    = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      used_r      <= '0;
      formatted_r <= 1'b0;
      hint_r      <= SCAN_W'(1);
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      formatted_r <= formatted_nxt;
      hint_r      <= hint_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    link_r     <= link_nxt;
    scan_r     <= scan_nxt;
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_hint_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    formatted_r |-> hint_r != '0)
    else $error("free-search hint points at entry zero");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= NUM_ENTRIES)
    else $error("used entry count exceeds table size");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r != BK_IDLE && state_r != BK_DONE && state_r != BK_DISPATCH))
    else $error("table write outside an operation");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.status == ST_FULL) |-> out_data_r.result_index == '0)
    else $error("table full result carries an entry index");

endmodule

// ===== tb/sv/allocation_table_chain_manager_tb.sv =====
module allocation_table_chain_manager_tb;
  import actm_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1160;
  localparam int CHAIN_LEN    = 200;
  localparam int CYCLE_LIMIT  = 4000000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
  } tbl_cmd_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  allocation_table_chain_manager uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow of the allocation table
  logic [LINK_W-1:0] link_tbl [NUM_ENTRIES];
  int unsigned       used_cnt  = 0;
  bit                fmt_done  = 1'b0;
  int                free_hint = 1;
  int                top_used  = 0;

  tbl_cmd_t cmd_backlog [$];
  result_t  due_results [$];
  tbl_cmd_t nxt;
  logic [OP_W-1:0]  cur_op  = '0;
  logic [IDX_W-1:0] cur_idx = '0;
  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int unsigned stall_tick = 0;

  function automatic int grab_lowest_free();
    for (int i = free_hint; i < SEARCH_SPAN; i++) begin
      if (link_tbl[i] == '0) begin
        free_hint = i;
        return i;
      end
    end
    free_hint = SEARCH_SPAN;
    return 0;
  endfunction

  function automatic result_t run_table_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    result_t           r;
    logic [LINK_W-1:0] v;
    int                e;
    int                cur;
    bit                idx_bad;
    r = '0;
    r.status = ST_OK;
    idx_bad = (int'(idx) >= NUM_ENTRIES);
    if (op == OP_FORMAT) begin
      for (int i = 0; i < NUM_ENTRIES; i++)
        link_tbl[i] = (i < RESERVED_ENTRIES) ? END_MARK : '0;
      used_cnt  = RESV_USED;
      fmt_done  = 1'b1;
      free_hint = 1;
      top_used  = (RESV_USED > 0) ? RESV_USED - 1 : 0;
    end else if (!fmt_done || op > OP_COUNT) begin
      r.status = ST_BAD;
    end else begin
      case (op)
        OP_ALLOC: begin
          e = grab_lowest_free();
          if (e == 0) begin
            r.status = ST_FULL;
          end else begin
            link_tbl[e] = END_MARK;
            used_cnt++;
            r.result_index = IDX_W'(e);
            if (e > top_used) top_used = e;
          end
        end
        OP_APPEND: begin
          if (idx_bad || link_tbl[idx] == '0) begin
            r.status = ST_BAD;
          end else begin
            e = grab_lowest_free();
            if (e == 0) begin
              r.status = ST_FULL;
            end else begin
              // splice after the given entry
              link_tbl[e]   = link_tbl[idx];
              link_tbl[idx] = LINK_W'(e);
              used_cnt++;
              r.result_index = IDX_W'(e);
              if (e > top_used) top_used = e;
            end
          end
        end
        OP_FREE: begin
          if (idx_bad || link_tbl[idx] == '0) begin
            r.status = ST_BAD;
          end else begin
            cur = idx;
            while (1) begin
              v = link_tbl[cur];
              if (v == '0) begin
                r.status = ST_LOOP;
                break;
              end
              link_tbl[cur] = '0;
              r.freed_or_used = r.freed_or_used + 1'b1;
              if (used_cnt > 0) used_cnt--;
              if (cur != 0 && cur < free_hint) free_hint = cur;
              if (v == END_MARK) break;
              if (int'(v) >= NUM_ENTRIES) begin
                r.status = ST_BAD;
                break;
              end
              cur = v;
            end
          end
        end
        OP_NEXT: begin
          if (idx_bad || link_tbl[idx] == '0)
            r.status = ST_BAD;
          else if (link_tbl[idx] == END_MARK)
            r.end_of_chain = 1'b1;
          else
            r.result_index = IDX_W'(link_tbl[idx]);
        end
        default: begin
          r.freed_or_used = CNT_W'(used_cnt);
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_live();
    int c;
    c = 0;
    for (int k = 0; k < 8; k++) begin
      c = $urandom_range(0, top_used);
      if (link_tbl[c] != '0) return IDX_W'(c);
    end
    return IDX_W'(c);
  endfunction

  task automatic queue_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    tbl_cmd_t c;
    c.op  = op;
    c.idx = idx;
    cmd_backlog.push_back(c);
    pushed_cnt++;
  endtask

  task automatic wait_accepted();
    while (accepted_cnt != pushed_cnt) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, int want, int got);
    err_cnt++;
    $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(run_table_op(cur_op, cur_idx));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || cmd_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          nxt = cmd_backlog.pop_front();
          cur_op  = nxt.op;
          cur_idx = nxt.idx;
          in_tdata  <= {7'b0, nxt.idx, nxt.op};
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96) :
                                                       $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall pattern changes with bits 9:8 of a free-running tick count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_tick++;
      case (stall_tick[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 3) != 0);
        2'd2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (stall_tick[3:0] == 4'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (due_results.size() == 0) begin
        err_cnt++;
        $error("result item with none pending: %h", out_tdata);
      end else begin
        want = due_results.pop_front();
        if (got.result_index !== want.result_index)
          report_mismatch("result_index", want.result_index, got.result_index);
        if (got.end_of_chain !== want.end_of_chain)
          report_mismatch("end_of_chain", want.end_of_chain, got.end_of_chain);
        if (got.freed_or_used !== want.freed_or_used)
          report_mismatch("freed_or_used", want.freed_or_used, got.freed_or_used);
        if (got.status !== want.status)
          report_mismatch("status", want.status, got.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                 r;
    int                 n;
    int                 rand_done;
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   idx;
    rand_done = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) link_tbl[i] = '0;

    // before the first format every operation is refused
    queue_cmd(OP_ALLOC, 14'd0);
    queue_cmd(OP_APPEND, 14'd0);
    queue_cmd(OP_FREE, 14'h3FFF);
    queue_cmd(OP_NEXT, 14'd0);
    queue_cmd(OP_COUNT, 14'h3FFF);
    queue_cmd(OP_SPARE6, 14'h2AAA);
    queue_cmd(OP_SPARE7, 14'h1555);
    queue_cmd(OP_FORMAT, 14'h3FFF);
    queue_cmd(OP_COUNT, 14'd0);
    queue_cmd(OP_NEXT, 14'd0);
    queue_cmd(OP_NEXT, 14'h3FFF);
    queue_cmd(OP_ALLOC, 14'd0);
    queue_cmd(OP_APPEND, 14'd3);
    queue_cmd(OP_NEXT, 14'd3);
    queue_cmd(OP_APPEND, 14'd3);      // splice inside the chain
    queue_cmd(OP_NEXT, 14'd5);
    queue_cmd(OP_FREE, 14'd4);        // leaves a broken link behind
    queue_cmd(OP_FREE, 14'd3);
    queue_cmd(OP_ALLOC, 14'd0);
    queue_cmd(OP_APPEND, 14'd3);
    queue_cmd(OP_FREE, 14'd4);
    queue_cmd(OP_APPEND, 14'd3);      // reuse of the dangling target
    queue_cmd(OP_FREE, 14'd3);
    queue_cmd(OP_FREE, 14'd3);
    queue_cmd(OP_APPEND, 14'h3FFF);
    queue_cmd(OP_SPARE6, 14'd0);
    queue_cmd(OP_SPARE7, 14'h3FFF);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // build one long chain, then walk and free it
    queue_cmd(OP_FORMAT, 14'd0);
    queue_cmd(OP_ALLOC, 14'd0);
    for (int i = RESERVED_ENTRIES; i < RESERVED_ENTRIES + CHAIN_LEN; i++)
      queue_cmd(OP_APPEND, IDX_W'(i));
    queue_cmd(OP_ALLOC, 14'd0);
    queue_cmd(OP_APPEND, 14'h3FFF);
    queue_cmd(OP_COUNT, 14'd0);
    queue_cmd(OP_NEXT, 14'h3FFF);
    queue_cmd(OP_NEXT, 14'd8000);
    queue_cmd(OP_NEXT, 14'd100);
    queue_cmd(OP_FREE, IDX_W'(RESERVED_ENTRIES));
    queue_cmd(OP_COUNT, 14'd0);
    queue_cmd(OP_ALLOC, 14'd0);
    queue_cmd(OP_FREE, 14'd0);        // entry zero is never handed out again
    queue_cmd(OP_ALLOC, 14'd0);
    queue_cmd(OP_COUNT, 14'd0);
    wait_drained();

    while (rand_done < RANDOM_ITEMS) begin
      wait_accepted();
      if (rand_done % 300 == 299) wait_drained();
      n = $urandom_range(1, 6);
      repeat (n) begin
        r = $urandom_range(0, 999);
        idx = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
        if (r < 3) begin
          op = OP_FORMAT;
        end else if (r < 200) begin
          op = OP_ALLOC;
        end else if (r < 480) begin
          op = OP_APPEND;
          idx = pick_live();
        end else if (r < 650) begin
          op = OP_FREE;
          idx = pick_live();
        end else if (r < 850) begin
          op = OP_NEXT;
          idx = pick_live();
        end else if (r < 920) begin
          op = OP_COUNT;
        end else begin
          op = OP_W'($urandom_range(1, 7));
        end
        queue_cmd(op, idx);
        rand_done++;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
